### rtl/core/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared types and constants of the SOM neuron weight update unit.
// ----------------------------------------------------------------------------
package som_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int WEIGHT_W         = 32;
	localparam int INDEX_W          = 6;
	localparam int LEN_W            = 7;
	localparam int ERROR_W          = 64;
	localparam int COUNT_W          = 32;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_ADD   = 2'd1,
		OP_SCALE = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	// stage enables from the sequencer to the datapath
	typedef struct packed {
		logic diff_en;
		logic mul_en;
	} dp_ctrl_t;

endpackage

### rtl/core/som_weight_ram.sv
// ----------------------------------------------------------------------------
// som_weight_ram
// Weight store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module som_weight_ram
	import som_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMENTS_DEF
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic signed [WEIGHT_W-1:0]                   wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic signed [WEIGHT_W-1:0]                   rdata
);

	logic signed [WEIGHT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/som_update_dp.sv
// ----------------------------------------------------------------------------
// som_update_dp
// Weight arithmetic: difference stage, multiply stage, round/saturate.
// ----------------------------------------------------------------------------
module som_update_dp
	import som_pkg::*;
(
	input  logic                        clk,
	input  dp_ctrl_t                    ctrl,
	input  op_t                         op,
	input  logic signed [WEIGHT_W-1:0]  val,
	input  logic signed [WEIGHT_W-1:0]  coef,
	input  logic signed [WEIGHT_W-1:0]  rd_data,
	output logic signed [WEIGHT_W-1:0]  new_w,
	output logic [ERROR_W-1:0]          sq
);

	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

	logic signed [WEIGHT_W-1:0] w_s1;
	logic signed [32:0]         d_s1;
	logic signed [32:0]         mb_s1;
	logic signed [64:0]         prod_s2;
	logic [ERROR_W-1:0]         sq_s2;

	logic signed [32:0] d;
	logic [32:0]        ad_full;
	logic [31:0]        ad;
	logic signed [64:0] prod;
	logic signed [64:0] biased;
	logic signed [48:0] rnd;
	logic signed [49:0] nw;

	// stage 1: old weight arrives from the store, take the difference
	assign d = 33'(val) - 33'(rd_data);

	always_ff @(posedge clk) begin
		if (ctrl.diff_en) begin
			w_s1  <= rd_data;
			d_s1  <= d;
			mb_s1 <= (op == OP_SCALE) ? 33'(rd_data) : d;
		end
	end

	// stage 2: one shared signed multiplier plus the error square
	assign ad_full = d_s1[32] ? 33'(-d_s1) : 33'(d_s1);
	assign ad      = ad_full[31:0];
	assign prod    = 65'(coef) * 65'(mb_s1);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= prod;
			sq_s2   <= ERROR_W'(ad) * ERROR_W'(ad);
		end
	end

	// write-back: round half up, add, saturate
	assign biased = prod_s2 + 65'sd32768;
	assign rnd    = biased[64:16];

	always_comb begin
		unique case (op)
			OP_MAP:   nw = 50'(w_s1) + 50'(rnd);
			OP_ADD:   nw = 50'(w_s1) + 50'(val);
			OP_SCALE: nw = 50'(rnd);
			OP_LOAD:  nw = 50'(val);
			default:  nw = 50'(val);
		endcase
	end

	always_comb begin
		if (nw > SAT_HI) begin
			new_w = SAT_HI[WEIGHT_W-1:0];
		end else if (nw < SAT_LO) begin
			new_w = SAT_LO[WEIGHT_W-1:0];
		end else begin
			new_w = nw[WEIGHT_W-1:0];
		end
	end

	assign sq = sq_s2;

endmodule

### rtl/core/som_neuron_weight_update_unit.sv
// ----------------------------------------------------------------------------
// som_neuron_weight_update_unit
// One Kohonen SOM neuron: Q16.16 weight vector with map, add, scale and load.
// ----------------------------------------------------------------------------
// Each transfer on the item channel addresses one weight element and yields
// exactly one result: the element after the operation, the squared-error
// total (Q32.32, saturating) and the mapped-vector count (saturating). An
// item passes from its transfer to its result through a read of the
// weight store, a difference stage, a multiply stage and a write-back; the
// next item transfers on the cycle after write-back, so the unit takes no
// new item while one is in flight, set by the single read-modify-write path
// through the weight store. A finished result sits in an output register,
// so a new item is taken while the result still waits. After reset the
// unit runs a clearing pass over all MAX_ELEMENTS entries, zeroing the
// weight store one entry per cycle; items are stalled during it,
// configuration writes are taken. Elements at or above the effective
// vector length (vector_length clamped to MAX_ELEMENTS) change nothing and
// return a zero weight. Write vector_length only while the unit is idle.
// ----------------------------------------------------------------------------
module som_neuron_weight_update_unit
	import som_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_write_en,
	input  logic [LEN_W-1:0]           cfg_write_data,
	// item channel
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 operation,
	input  logic [INDEX_W-1:0]         element_index,
	input  logic signed [WEIGHT_W-1:0] value,
	input  logic signed [WEIGHT_W-1:0] coefficient,
	input  logic                       last_element,
	// result channel
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [WEIGHT_W-1:0] weight_out,
	output logic [ERROR_W-1:0]         error_total,
	output logic [COUNT_W-1:0]         vector_count
);

	localparam int AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CmpW  = ($clog2(MAX_ELEMENTS + 1) > LEN_W) ?
		$clog2(MAX_ELEMENTS + 1) : LEN_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_WB
	} state_t;

	state_t state_q;

	// configuration and item registers
	logic [LEN_W-1:0]           len_q;
	op_t                        op_q;
	logic [AddrW-1:0]           addr_q;
	logic signed [WEIGHT_W-1:0] val_q;
	logic signed [WEIGHT_W-1:0] coef_q;
	logic                       last_q;
	logic                       use_q;
	logic [AddrW-1:0]           clr_q;

	// neuron state outside the store
	logic [ERROR_W-1:0] err_q;
	logic [COUNT_W-1:0] cnt_q;

	// result register
	logic                       res_valid_q;
	logic signed [WEIGHT_W-1:0] res_w_q;
	logic [ERROR_W-1:0]         res_err_q;
	logic [COUNT_W-1:0]         res_cnt_q;

	logic                       item_xfer;
	logic                       in_use;
	logic                       commit;
	logic                       ram_we;
	logic [AddrW-1:0]           ram_waddr;
	logic signed [WEIGHT_W-1:0] ram_wdata;
	logic signed [WEIGHT_W-1:0] ram_rdata;
	logic signed [WEIGHT_W-1:0] new_w;
	logic [ERROR_W-1:0]         sq;
	logic [ERROR_W:0]           err_sum;
	logic [ERROR_W-1:0]         err_next;
	logic [COUNT_W-1:0]         cnt_next;
	dp_ctrl_t                   dp_ctrl;

	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;

	// element is in use below both the written length and the store depth
	assign in_use = (CmpW'(element_index) < CmpW'(len_q)) &&
		(CmpW'(element_index) < CmpW'(MAX_ELEMENTS));

	// write-back completes once the result register is free or being taken
	assign commit = (state_q == ST_WB) && (!res_valid_q || !result_stall);

	assign dp_ctrl.diff_en = (state_q == ST_DIFF);
	assign dp_ctrl.mul_en  = (state_q == ST_MUL);

	// store writes: clearing pass, then write-back of in-use elements
	always_comb begin
		priority if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = commit && use_q;
			ram_waddr = addr_q;
			ram_wdata = new_w;
		end
	end

	// error total and mapped count, both saturating
	assign err_sum  = {1'b0, err_q} + {1'b0, sq};
	assign err_next = err_sum[ERROR_W] ? '1 : err_sum[ERROR_W-1:0];
	assign cnt_next = (last_q && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;

	som_weight_ram #(
		.DEPTH (MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AddrW'(element_index)),
		.rdata (ram_rdata)
	);

	som_update_dp u_dp (
		.clk     (clk),
		.ctrl    (dp_ctrl),
		.op      (op_q),
		.val     (val_q),
		.coef    (coef_q),
		.rd_data (ram_rdata),
		.new_w   (new_w),
		.sq      (sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			len_q       <= LEN_RESET;
			err_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				len_q <= cfg_write_data;
			end

			// a new result may replace one taken on the same edge
			priority if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AddrW'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_xfer) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						res_w_q     <= use_q ? new_w : '0;
						if (use_q && (op_q == OP_MAP)) begin
							err_q     <= err_next;
							cnt_q     <= cnt_next;
							res_err_q <= err_next;
							res_cnt_q <= cnt_next;
						end else begin
							res_err_q <= err_q;
							res_cnt_q <= cnt_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// item capture; the store read runs in the same cycle
			if (item_xfer) begin
				op_q   <= op_t'(operation);
				addr_q <= AddrW'(element_index);
				val_q  <= value;
				coef_q <= coefficient;
				last_q <= last_element;
				use_q  <= in_use;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign weight_out   = res_w_q;
	assign error_total  = res_err_q;
	assign vector_count = res_cnt_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> (state_q == ST_DIFF))
		else $error("item transfer did not start the difference stage");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_WB)))
		else $error("weight store written outside clear or write-back");

	a_err_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (err_q >= $past(err_q)))
		else $error("error total decreased");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q >= $past(cnt_q)))
		else $error("mapped count decreased");

	a_result_needs_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_WB))
		else $error("result raised without a write-back");

endmodule

### tb/som_neuron_weight_update_unit_test.sv
// ----------------------------------------------------------------------------
// som_neuron_weight_update_unit_test
// Self-checking bench for the SOM neuron weight update unit. A shadow copy of
// the neuron (weights, error total, mapped count, vector length) is stepped on
// every item transfer. Each result transfer is compared field by field with
// the oldest outstanding prediction. Both channels idle at random, the vector
// length is changed between phases, and the run closes by driving the error
// total and the weights into saturation.
// ----------------------------------------------------------------------------
module som_neuron_weight_update_unit_test;
	import som_pkg::*;

	localparam int N_ELEM = MAX_ELEMENTS_DEF;

	// saturation bounds and handy Q16.16 values
	localparam logic signed [127:0] W_MAX = 128'sd2147483647;
	localparam logic signed [127:0] W_MIN = -128'sd2147483648;
	localparam logic signed [WEIGHT_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WEIGHT_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [WEIGHT_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [WEIGHT_W-1:0] Q_HALF  = 32'sh0000_8000;

	// generous wall: several times the slowest legal run
	localparam int RUN_LIMIT = 5_000_000;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [ERROR_W-1:0]         total;
		logic [COUNT_W-1:0]         vectors;
	} neuron_result_t;

	// Shadow neuron: stepped once per item transfer, holds the results that
	// the unit still owes us, oldest first.
	class neuron_shadow;
		logic signed [WEIGHT_W-1:0] weights [N_ELEM];
		logic [ERROR_W-1:0]         err_acc;
		logic [COUNT_W-1:0]         mapped;
		logic [LEN_W-1:0]           length;
		neuron_result_t             awaited [$];
		int                         mismatches;

		function new();
			foreach (weights[i])
				weights[i] = '0;
			err_acc    = '0;
			mapped     = '0;
			length     = LEN_RESET;
			mismatches = 0;
		endfunction

		// elements in use: the length register clamped to the store depth
		function int in_use();
			return (length > N_ELEM) ? N_ELEM : int'(length);
		endfunction

		function void take_item(op_t op, logic [INDEX_W-1:0] idx,
				logic signed [WEIGHT_W-1:0] val, logic signed [WEIGHT_W-1:0] coef,
				logic last);
			logic signed [127:0] w, v, c, d, nw;
			logic [127:0]        total;
			neuron_result_t      r;
			r.weight = '0;
			if (idx < in_use()) begin
				w = 128'(weights[idx]);
				v = 128'(val);
				c = 128'(coef);
				case (op)
					OP_MAP: begin
						// error is taken against the old weight, exact Q32.32
						d     = v - w;
						total = err_acc + d * d;
						err_acc = (total > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : total[ERROR_W-1:0];
						// round half up: add half an lsb, then floor
						nw = w + ((c * d + 32768) >>> 16);
						if (last && mapped != '1)
							mapped = mapped + 1'b1;
					end
					OP_ADD:   nw = w + v;
					OP_SCALE: nw = (w * c + 32768) >>> 16;
					default:  nw = v;
				endcase
				if (nw > W_MAX)
					weights[idx] = S32_MAX;
				else if (nw < W_MIN)
					weights[idx] = S32_MIN;
				else
					weights[idx] = nw[WEIGHT_W-1:0];
				r.weight = weights[idx];
			end
			// unused element: nothing moves, zero weight, current totals
			r.total   = err_acc;
			r.vectors = mapped;
			awaited.push_back(r);
		endfunction

		function void check_result(logic signed [WEIGHT_W-1:0] weight,
				logic [ERROR_W-1:0] total, logic [COUNT_W-1:0] vectors);
			neuron_result_t r;
			if (awaited.size() == 0) begin
				$error("result transfer with nothing outstanding (weight_out %0d)", weight);
				mismatches++;
				return;
			end
			r = awaited.pop_front();
			if (weight !== r.weight) begin
				$error("weight_out: expected %0d, actual %0d", r.weight, weight);
				mismatches++;
			end
			if (total !== r.total) begin
				$error("error_total: expected %0h, actual %0h", r.total, total);
				mismatches++;
			end
			if (vectors !== r.vectors) begin
				$error("vector_count: expected %0d, actual %0d", r.vectors, vectors);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write_en;
	logic [LEN_W-1:0]           cfg_write_data;
	logic                       item_valid;
	logic                       item_stall;
	logic [1:0]                 operation;
	logic [INDEX_W-1:0]         element_index;
	logic signed [WEIGHT_W-1:0] value;
	logic signed [WEIGHT_W-1:0] coefficient;
	logic                       last_element;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [WEIGHT_W-1:0] weight_out;
	logic [ERROR_W-1:0]         error_total;
	logic [COUNT_W-1:0]         vector_count;

	neuron_shadow board;

	// stretches of back-to-back traffic, one counter per side
	int send_calm = 0;
	int recv_calm = 0;

	som_neuron_weight_update_unit #(
		.MAX_ELEMENTS(N_ELEM)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.element_index (element_index),
		.value         (value),
		.coefficient   (coefficient),
		.last_element  (last_element),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.weight_out    (weight_out),
		.error_total   (error_total),
		.vector_count  (vector_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop in case a handshake never completes
	initial begin
		#(RUN_LIMIT);
		$display("som_neuron_weight_update_unit verification failed");
		$finish;
	end

	// Random idle wait before the next transfer, but now and then a run with
	// no wait so the pipeline also sees back-to-back traffic.
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(5, 25);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// uniform in [-2^bits, 2^bits]
	function automatic longint spread(int bits);
		return longint'($urandom_range(0, 2 ** (bits + 1))) - (longint'(1) << bits);
	endfunction

	// Q16.16 operand: mostly modest magnitudes, some full-range noise and
	// the corner values
	function automatic logic signed [WEIGHT_W-1:0] pick_q16();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return WEIGHT_W'(spread(20));
		if (sel < 8)
			return WEIGHT_W'(spread(24));
		if (sel == 8)
			return $urandom;
		case ($urandom_range(0, 4))
			0:       return S32_MAX;
			1:       return S32_MIN;
			2:       return '0;
			3:       return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	// One item transfer. Payload changes only at the falling edge and stays
	// put while stalled; the transfer is seen at the rising edge.
	task automatic send_item(input op_t op, input logic [INDEX_W-1:0] idx,
			input logic signed [WEIGHT_W-1:0] val, input logic signed [WEIGHT_W-1:0] coef,
			input logic last);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation     <= op;
		element_index <= idx;
		value         <= val;
		coefficient   <= coef;
		last_element  <= last;
		item_valid    <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		board.take_item(op, idx, val, coef, last);
		@(negedge clk);
	endtask

	// drop valid and let every outstanding result come home
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.awaited.size() != 0);
	endtask

	// called only with no item in flight: during the clearing pass or while idle
	task automatic write_length(input logic [LEN_W-1:0] len);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= len;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		board.length = len;
	endtask

	// Random traffic. Map items target a value near the current weight so
	// the error total keeps headroom; the other operations roam freely.
	// Half way through, the sender holds off until the unit has emptied.
	task automatic random_phase(input int n);
		op_t                        op;
		logic [INDEX_W-1:0]         idx;
		logic signed [WEIGHT_W-1:0] val, coef;
		logic                       last;
		int                         span, pick;
		longint                     near;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				drain();
			span = board.in_use();
			if (span > 0 && $urandom_range(0, 99) < 85)
				idx = INDEX_W'($urandom_range(0, span - 1));
			else
				idx = INDEX_W'($urandom_range(0, N_ELEM - 1));
			pick = $urandom_range(0, 19);
			op = (pick < 9) ? OP_MAP : (pick < 12) ? OP_ADD : (pick < 15) ? OP_SCALE : OP_LOAD;
			last = ($urandom_range(0, 3) == 0);
			val  = pick_q16();
			coef = pick_q16();
			if (op == OP_MAP) begin
				near = longint'(board.weights[idx]) + spread(($urandom_range(0, 9) == 0) ? 26 : 20);
				if (near > longint'(S32_MAX))
					near = longint'(S32_MAX);
				else if (near < longint'(S32_MIN))
					near = longint'(S32_MIN);
				val = near[WEIGHT_W-1:0];
				// usual learning rates sit between 0 and 1.0
				if ($urandom_range(0, 2) != 0)
					coef = $urandom_range(0, Q_ONE);
			end else if (op == OP_SCALE && $urandom_range(0, 1) == 1) begin
				coef = WEIGHT_W'(longint'(Q_ONE) + spread(14));
			end
			send_item(op, idx, val, coef, last);
		end
	endtask

	// Result side: holds stall for a random number of cycles per result,
	// then takes the next one and checks it.
	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = draw_wait(recv_calm);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!result_valid);
			board.check_result(weight_out, error_total, vector_count);
			@(negedge clk);
		end
	end

	initial begin
		board = new();
		// every input known from time zero
		arst_n         = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_write_data = LEN_RESET;
		item_valid     = 1'b0;
		operation      = OP_MAP;
		element_index  = '0;
		value          = '0;
		coefficient    = '0;
		last_element   = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register write lands during the clearing pass; items are simply
		// stalled until the store is zeroed.
		write_length(7'd64);

		// --- directed: saturation at both rails on every operation ---
		send_item(OP_LOAD,  6'd0,  S32_MAX, '0, 1'b1);       // last on load is ignored
		send_item(OP_LOAD,  6'd63, S32_MIN, '0, 1'b0);
		send_item(OP_ADD,   6'd0,  32'sd1, S32_MIN, 1'b1);   // clips high
		send_item(OP_ADD,   6'd63, -32'sd1, S32_MAX, 1'b0);  // clips low
		send_item(OP_SCALE, 6'd0,  S32_MIN, 32'sh0002_0000, 1'b1);
		send_item(OP_SCALE, 6'd63, '0, -Q_ONE, 1'b0);        // -MIN overflows
		// rounding: exact, tie upward from +0.5 lsb, tie upward from -0.5 lsb
		send_item(OP_LOAD,  6'd1,  32'sh0001_8000, '0, 1'b0);
		send_item(OP_SCALE, 6'd1,  '0, Q_HALF, 1'b0);
		send_item(OP_LOAD,  6'd2,  32'sd1, '0, 1'b0);
		send_item(OP_SCALE, 6'd2,  '0, Q_HALF, 1'b0);
		send_item(OP_LOAD,  6'd3,  -32'sd1, '0, 1'b0);
		send_item(OP_SCALE, 6'd3,  '0, Q_HALF, 1'b0);
		// map: plain step, huge coefficient, most negative coefficient
		send_item(OP_MAP,   6'd4,  Q_ONE, Q_HALF, 1'b0);
		send_item(OP_MAP,   6'd4,  Q_ONE, S32_MAX, 1'b1);
		send_item(OP_MAP,   6'd5,  Q_ONE, S32_MIN, 1'b1);
		send_item(OP_MAP,   6'd5,  -Q_ONE, '0, 1'b0);        // zero rate, error only
		send_item(OP_MAP,   6'd63, '0, Q_ONE, 1'b1);         // top element in use
		send_item(OP_SCALE, 6'd4,  '0, '0, 1'b1);
		send_item(OP_ADD,   6'd6,  S32_MIN, '0, 1'b0);
		send_item(OP_ADD,   6'd6,  S32_MIN, '0, 1'b0);
		drain();

		// --- random phases, the length changed only with the unit idle ---
		random_phase(180);
		drain();
		write_length(7'd1);
		random_phase(60);
		drain();
		write_length(7'd0);          // nothing in use: every item ignored
		random_phase(20);
		drain();
		write_length(7'd127);        // clamped to the store depth
		random_phase(170);
		drain();
		write_length(7'd40);
		random_phase(120);
		drain();
		write_length(LEN_W'($urandom_range(1, 63)));
		random_phase(110);
		drain();
		write_length(7'd100);
		random_phase(110);

		// --- closing: full-scale differences push the error total to its
		// ceiling, then it must stay there ---
		send_item(OP_LOAD, 6'd7, S32_MIN, '0, 1'b0);
		send_item(OP_MAP,  6'd7, S32_MAX, '0, 1'b1);
		send_item(OP_MAP,  6'd7, S32_MAX, '0, 1'b1);
		send_item(OP_MAP,  6'd7, S32_MAX, S32_MAX, 1'b0);
		send_item(OP_MAP,  6'd7, S32_MIN, S32_MAX, 1'b1);
		send_item(OP_LOAD, 6'd8, S32_MAX, '0, 1'b0);
		send_item(OP_MAP,  6'd8, S32_MIN, S32_MIN, 1'b1);
		random_phase(12);

		drain();
		repeat (16) @(negedge clk);
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("som_neuron_weight_update_unit verification clean");
		else
			$display("som_neuron_weight_update_unit verification failed");
		$finish;
	end

endmodule
